>>> hdl/afe_pkg.sv
// ----------------------------------------------------------------------------
// afe_pkg
// Shared types and constants of the audio fade envelope: configuration
// register indexes, the configuration bundle and the controller commands.
// ----------------------------------------------------------------------------
package afe_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FADE_IN_FRAMES  = 3'd0;
  localparam logic [2:0] REG_FADE_OUT_FRAMES = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd2;
  localparam logic [2:0] REG_CLIP_FRAMES     = 3'd3;
  localparam logic [2:0] REG_SMOOTH_CURVE    = 3'd4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int LEN_BITS       = 24;
  localparam int GAIN_BITS      = 16;

  // One quotient bit per divider step
  localparam int DIV_STEPS = GAIN_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  // Smoothstep constant 3.0 in Q.16 on 18 bits
  localparam logic [17:0] THREE_Q16 = 18'h30000;

  typedef struct packed {
    logic [LEN_BITS-1:0] fade_in_frames;
    logic [LEN_BITS-1:0] fade_out_frames;
    logic [3:0]          channel_count;
    logic [LEN_BITS-1:0] clip_frames;
    logic                smooth_curve;
  } afe_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_SQ,
    OP_MUL_SH,
    OP_SHAPE,
    OP_MUL_APPLY,
    OP_WRITE,
    OP_EMIT
  } afe_op_t;

  typedef struct packed {
    afe_op_t op;
    logic    sel_out;
  } afe_cmd_t;

  typedef struct packed {
    logic in_act;
    logic out_act;
    logic smooth;
    logic out_free;
  } afe_status_t;

endpackage

>>> hdl/afe_if.sv
// ----------------------------------------------------------------------------
// afe_if
// Stream channels of the audio fade envelope: input samples and results.
// ----------------------------------------------------------------------------
interface afe_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface afe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               clip_end;

  modport source (output valid, output sample_out, output clip_end, input ready);
  modport sink   (input valid, input sample_out, input clip_end, output ready);
endinterface

>>> hdl/afe_ctrl.sv
// ----------------------------------------------------------------------------
// afe_ctrl
// Sequencer of the fade envelope: walks one request through the fade-in
// and fade-out ramps (divide, optional smoothstep, gain) and emits it.
// ----------------------------------------------------------------------------
module afe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  afe_pkg::afe_status_t status,
  output afe_pkg::afe_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_DIV,
    S_SQ,
    S_SH,
    S_SHAPE,
    S_APPLY,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t                        state;
  logic                          phase_out;
  logic [afe_pkg::STEP_BITS-1:0] step_cnt;
  logic                          ramp_act;

  assign ramp_act = phase_out ? status.out_act : status.in_act;
  assign in_ready = (state == S_IDLE);

  // Decode the datapath command from the state
  always_comb begin
    cmd.op      = afe_pkg::OP_NONE;
    cmd.sel_out = phase_out;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = afe_pkg::OP_LOAD;
      S_PICK:  if (ramp_act) cmd.op = afe_pkg::OP_DIV_INIT;
      S_DIV:   cmd.op = afe_pkg::OP_DIV_STEP;
      S_SQ:    cmd.op = afe_pkg::OP_MUL_SQ;
      S_SH:    cmd.op = afe_pkg::OP_MUL_SH;
      S_SHAPE: cmd.op = afe_pkg::OP_SHAPE;
      S_APPLY: cmd.op = afe_pkg::OP_MUL_APPLY;
      S_WRITE: cmd.op = afe_pkg::OP_WRITE;
      S_EMIT:  if (status.out_free) cmd.op = afe_pkg::OP_EMIT;
      default: cmd.op = afe_pkg::OP_NONE;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_out <= 1'b0;
      step_cnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase_out <= 1'b0;
            state     <= S_PICK;
          end
        end
        S_PICK: begin
          if (ramp_act) begin
            step_cnt <= '0;
            state    <= S_DIV;
          end else if (!phase_out) begin
            phase_out <= 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == afe_pkg::STEP_BITS'(afe_pkg::DIV_STEPS - 1)) begin
            state <= status.smooth ? S_SQ : S_APPLY;
          end
        end
        S_SQ:    state <= S_SH;
        S_SH:    state <= S_SHAPE;
        S_SHAPE: state <= S_APPLY;
        S_APPLY: state <= S_WRITE;
        S_WRITE: begin
          if (!phase_out) begin
            phase_out <= 1'b1;
            state     <= S_PICK;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/afe_datapath.sv
// ----------------------------------------------------------------------------
// afe_datapath
// Frame and channel counters, serial gain divider, shared multiplier and
// the output register of the fade envelope.
// ----------------------------------------------------------------------------
module afe_datapath #(
  parameter int FRAME_BITS   = 24,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  afe_pkg::afe_cfg_t    cfg,
  input  afe_pkg::afe_cmd_t    cmd,
  output afe_pkg::afe_status_t status,
  input  logic signed [15:0]   sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   sample_out,
  output logic                 clip_end
);

  localparam int CW      = ((FRAME_BITS > afe_pkg::LEN_BITS) ? FRAME_BITS
                                                             : afe_pkg::LEN_BITS) + 1;
  localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LB      = afe_pkg::LEN_BITS;
  localparam int GB      = afe_pkg::GAIN_BITS;

  // Counters and sample
  logic [FRAME_BITS-1:0] frame_pos;
  logic [CH_BITS-1:0]    chan_pos;
  logic signed [15:0]    x;
  logic                  in_act;
  logic                  out_act;

  // Divider and multiplier
  logic [LB-1:0] rem;
  logic [LB-1:0] len;
  logic [GB-1:0] quo;
  logic [34:0]   prod;

  // Widened views for compares
  logic [CW-1:0] f_w;
  logic [CW-1:0] clip_w;
  logic [CW-1:0] fin_w;
  logic [CW-1:0] fout_w;
  logic [CW-1:0] num_out_w;
  logic [4:0]    chans;
  logic          last_chan;
  logic          last_frame;
  logic [LB:0]   rem_dbl;
  logic [LB:0]   rem_sub;
  logic [16:0]   mul_a;
  logic [17:0]   mul_b;
  logic [16:0]   mag;
  logic [15:0]   gain_prod;

  assign f_w    = CW'(frame_pos);
  assign clip_w = (cfg.clip_frames == '0) ? CW'(1) : CW'(cfg.clip_frames);
  assign fin_w  = CW'(cfg.fade_in_frames);
  assign fout_w = CW'(cfg.fade_out_frames);

  // Fade-out numerator: frames left after this one, zero past clip end
  assign num_out_w = (f_w < clip_w) ? (clip_w - CW'(1) - f_w) : '0;

  // Effective channel count clamped to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == 4'd0) begin
      chans = 5'd1;
    end else if (5'(cfg.channel_count) > 5'(MAX_CHANNELS)) begin
      chans = 5'(MAX_CHANNELS);
    end else begin
      chans = 5'(cfg.channel_count);
    end
  end

  assign last_chan  = (5'(chan_pos) + 5'd1) >= chans;
  assign last_frame = (f_w + CW'(1)) >= clip_w;

  // Restoring divider step
  assign rem_dbl = {rem, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, len};

  // Magnitude of the sample
  assign mag = x[15] ? (17'd0 - 17'(x)) : 17'(x);

  // Select multiplier operands
  always_comb begin
    unique case (cmd.op)
      afe_pkg::OP_MUL_SQ: begin
        mul_a = {1'b0, quo};
        mul_b = {2'b00, quo};
      end
      afe_pkg::OP_MUL_SH: begin
        mul_a = {1'b0, prod[31:16]};
        mul_b = afe_pkg::THREE_Q16 - {1'b0, quo, 1'b0};
      end
      default: begin
        mul_a = mag;
        mul_b = {2'b00, quo};
      end
    endcase
  end

  assign gain_prod = prod[31:16];

  assign status.in_act   = in_act;
  assign status.out_act  = out_act;
  assign status.smooth   = cfg.smooth_curve;
  assign status.out_free = !out_valid || out_ready;

  // Control state: counters, ramp flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
      chan_pos  <= '0;
      in_act    <= 1'b0;
      out_act   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on emit, drop it once the result is taken
      if (cmd.op == afe_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        afe_pkg::OP_LOAD: begin
          in_act  <= (fin_w != '0) && (fin_w <= clip_w) && (f_w < fin_w);
          out_act <= (fout_w != '0) && (fout_w <= clip_w) &&
                     ((f_w + fout_w) >= clip_w);
        end
        afe_pkg::OP_EMIT: begin
          if (last_chan) begin
            chan_pos  <= '0;
            frame_pos <= last_frame ? '0 : (frame_pos + 1'b1);
          end else begin
            chan_pos <= chan_pos + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: sample, divider, product, result
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      afe_pkg::OP_LOAD: x <= sample_in;
      afe_pkg::OP_DIV_INIT: begin
        quo <= '0;
        if (cmd.sel_out) begin
          rem <= LB'(num_out_w);
          len <= cfg.fade_out_frames;
        end else begin
          rem <= LB'(f_w);
          len <= cfg.fade_in_frames;
        end
      end
      afe_pkg::OP_DIV_STEP: begin
        if (rem_dbl >= {1'b0, len}) begin
          rem <= rem_sub[LB-1:0];
          quo <= {quo[GB-2:0], 1'b1};
        end else begin
          rem <= rem_dbl[LB-1:0];
          quo <= {quo[GB-2:0], 1'b0};
        end
      end
      afe_pkg::OP_MUL_SQ,
      afe_pkg::OP_MUL_SH,
      afe_pkg::OP_MUL_APPLY: prod <= 35'(mul_a * mul_b);
      afe_pkg::OP_SHAPE: quo <= (prod[34:32] != 3'd0) ? '1 : prod[31:16];
      afe_pkg::OP_WRITE: x <= x[15] ? (16'sd0 - $signed(gain_prod)) : $signed(gain_prod);
      afe_pkg::OP_EMIT: begin
        sample_out <= x;
        clip_end   <= last_chan && last_frame;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/audio_fade_envelope_top.sv
// ----------------------------------------------------------------------------
// audio_fade_envelope_top
// Fade-in / fade-out envelope over one interleaved clip of 16-bit samples.
// ----------------------------------------------------------------------------
// Each request carries one interleaved sample; the block keeps the frame and
// channel position, scales samples of the first fade_in_frames frames by
// f/fade_in_frames and of the last fade_out_frames frames by the falling
// ramp, optionally shaped by smoothstep, and returns one result per request
// with clip_end marking the last sample of the clip. Each active ramp runs
// the 16-step serial gain divider, then the shared multiplier once for the
// gain, or three times with smooth_curve set (square, shape term, gain).
// No new request is taken while one is in work; the input is taken again
// while a finished result waits in the output register.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module audio_fade_envelope_top #(
  parameter int FRAME_BITS   = 24,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  afe_in_if.sink                                 in_stream,
  afe_out_if.source                              out_stream,
  input  logic                                   cfg_we,
  input  logic [afe_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [afe_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  afe_pkg::afe_cfg_t    cfg;
  afe_pkg::afe_cmd_t    cmd;
  afe_pkg::afe_status_t status;
  logic                 in_ready;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_in_frames  <= '0;
      cfg.fade_out_frames <= '0;
      cfg.channel_count   <= 4'd1;
      cfg.clip_frames     <= 24'd1;
      cfg.smooth_curve    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afe_pkg::REG_FADE_IN_FRAMES:  cfg.fade_in_frames  <= cfg_data;
        afe_pkg::REG_FADE_OUT_FRAMES: cfg.fade_out_frames <= cfg_data;
        afe_pkg::REG_CHANNEL_COUNT:   cfg.channel_count   <= cfg_data[3:0];
        afe_pkg::REG_CLIP_FRAMES:     cfg.clip_frames     <= cfg_data;
        afe_pkg::REG_SMOOTH_CURVE:    cfg.smooth_curve    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stream.ready = in_ready;

  afe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  afe_datapath #(
    .FRAME_BITS   (FRAME_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (in_stream.sample_in),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .sample_out (out_stream.sample_out),
    .clip_end   (out_stream.clip_end)
  );

endmodule
